>>> src/keepalive_peer_liveness_table_assert.svh
// assertion macros used by the liveness table checker
// no dependencies; included by the checker file
`ifndef KEEPALIVE_PEER_LIVENESS_TABLE_ASSERT_SVH
`define KEEPALIVE_PEER_LIVENESS_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KPLT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kplt assertion failed");

// next-cycle implication, checked outside reset
`define KPLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kplt assertion failed");

`endif

>>> src/kplt_pkg.sv
// shared types, codes and helpers for the keepalive liveness table
// no dependencies
package kplt_pkg;

    localparam int ID_W       = 16;
    localparam int MISS_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] OP_REQUEST  = 2'd0;
    localparam logic [1:0] OP_RESPONSE = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic KIND_REQUEST  = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MY_ID        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 1'd1;

    localparam logic [ID_W-1:0]   ANY_ID           = 16'd0;
    localparam logic [ID_W-1:0]   MY_ID_RESET      = 16'd1;
    localparam logic [MISS_W-1:0] MAX_ATTEMPTS_RST = 4'd3;
    localparam logic [MISS_W-1:0] MISS_SAT         = 4'd15;

    typedef struct packed {
        logic [ID_W-1:0]   node;
        logic [MISS_W-1:0] misses;
    } peer_entry_t;

    // saturating miss counter increment
    function automatic logic [MISS_W-1:0] age_miss(input logic [MISS_W-1:0] count);
        logic [MISS_W-1:0] res;
        res = (count < MISS_SAT) ? count + 4'd1 : MISS_SAT;
        return res;
    endfunction

endpackage

>>> src/kplt_if.sv
// valid/ready channel interfaces for the keepalive liveness table
// depends on kplt_pkg
interface kplt_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic [kplt_pkg::ID_W-1:0] source_id;
    logic [kplt_pkg::ID_W-1:0] destination_id;

    modport source (output valid, output operation, output source_id,
                    output destination_id, input ready);
    modport sink (input valid, input operation, input source_id,
                  input destination_id, output ready);
endinterface

interface kplt_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [kplt_pkg::ID_W-1:0] send_to;
    logic                      send_kind;
    logic                      peer_table_full;

    modport source (output valid, output send_to, output send_kind,
                    output peer_table_full, input ready);
    modport sink (input valid, input send_to, input send_kind,
                  input peer_table_full, output ready);
endinterface

>>> src/kplt_peer_ram.sv
// peer table memory: one write port, one read port, registered read data
// depends on kplt_pkg
module kplt_peer_ram #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_idx,
    input  kplt_pkg::peer_entry_t             wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_idx,
    output kplt_pkg::peer_entry_t             rd_data
);

    kplt_pkg::peer_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_idx];
        end
    end

endmodule

>>> src/keepalive_peer_liveness_table.sv
// keepalive liveness table top level: host tracking, peer scan sequencer, output register
// depends on kplt_pkg, kplt_if, kplt_peer_ram
//
// usage
//  cmd channel takes one item per message or timer event: operation (request received,
//  response received, tick), source_id and destination_id. rsp channel gives at most one
//  outgoing keepalive per item: send_to, send_kind, peer_table_full. cfg port writes my_id
//  (index 0) and max_attempts (index 1); the user does so only while the block is idle; it is not enforced.
// timing
//  responses, requests for other nodes and unknown operations finish in the accept cycle
//  and give no item; cmd.ready stays high.
//  a request to any node (not this one) skips the walk and goes to the closing state,
//  which loads its answer into the output register; the next item is taken after it.
//  a request to this node and a tick walk every peer entry through the one read port of
//  the peer memory: a read of each entry in turn, a compare stage on each read result,
//  leaving the walk once the last compare is done, then the closing state, which loads
//  the answer into the output register and lets the next item in.
// reset
//  host cleared to id 0 with zero misses, all peer valid bits cleared, my_id = 1,
//  max_attempts = 3; the memory itself is not cleared, valid bits gate it.
// back-pressure
//  the result sits in an output register; a new item is taken while it waits, and the
//  block only holds in its closing cycle while the register is full and not being drained.
module keepalive_peer_liveness_table #(
    parameter int MAX_PEERS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    kplt_cmd_if.sink                          cmd,
    kplt_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [kplt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kplt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(MAX_PEERS > 1 ? MAX_PEERS : 2);
    localparam int CNT_W = $clog2(MAX_PEERS + 1) > IDX_W ? $clog2(MAX_PEERS + 1) : IDX_W + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // configuration
    logic [kplt_pkg::ID_W-1:0]   my_id_reg;
    logic [kplt_pkg::MISS_W-1:0] max_attempts_reg;

    // host tracking
    logic [kplt_pkg::ID_W-1:0]   host_node_reg, host_node_next;
    logic [kplt_pkg::MISS_W-1:0] host_misses_reg, host_misses_next;

    // sequencer
    logic [1:0]                  state_reg, state_next;
    logic                        tick_reg, tick_next;
    logic [kplt_pkg::ID_W-1:0]   src_reg, src_next;
    logic [CNT_W-1:0]            issue_cnt_reg, issue_cnt_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic                        hit_reg, hit_next;
    logic                        free_found_reg, free_found_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;
    logic [MAX_PEERS-1:0]        peer_valid_reg, peer_valid_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [kplt_pkg::ID_W-1:0]   send_to_reg, send_to_next;
    logic                        send_kind_reg, send_kind_next;
    logic                        full_reg, full_next;

    // memory ports
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_idx;
    kplt_pkg::peer_entry_t       wr_data;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_idx;
    kplt_pkg::peer_entry_t       rd_data;

    logic                        accept;
    logic                        finish_go;
    logic                        entry_valid;
    logic [kplt_pkg::MISS_W-1:0] aged_miss;
    logic [kplt_pkg::MISS_W-1:0] host_aged;
    logic                        for_me;
    logic                        for_any;

    kplt_peer_ram #(
        .DEPTH (MAX_PEERS)
    ) u_peer_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    assign cmd.ready       = (state_reg == ST_IDLE);
    assign accept          = cmd.valid && cmd.ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.send_to     = send_to_reg;
    assign rsp.send_kind   = send_kind_reg;
    assign rsp.peer_table_full = full_reg;

    assign for_me    = (cmd.destination_id == my_id_reg);
    assign for_any   = (cmd.destination_id == kplt_pkg::ANY_ID);
    assign host_aged = kplt_pkg::age_miss(host_misses_reg);

    // closing cycle may go ahead once the output register is free or being drained
    assign finish_go = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);

    // compare stage operands: read data belongs to cmp_idx_reg
    assign entry_valid = peer_valid_reg[cmp_idx_reg];
    assign aged_miss   = kplt_pkg::age_miss(rd_data.misses);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_id_reg        <= kplt_pkg::MY_ID_RESET;
            max_attempts_reg <= kplt_pkg::MAX_ATTEMPTS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kplt_pkg::REG_MY_ID:
                begin
                    my_id_reg <= cfg_data;
                end
                kplt_pkg::REG_MAX_ATTEMPTS:
                begin
                    max_attempts_reg <= cfg_data[kplt_pkg::MISS_W-1:0];
                end
                default:
                begin
                    my_id_reg <= my_id_reg;
                end
            endcase
        end
    end

    // sequencer, host update, peer walk and result build
    always_comb
    begin
        state_next       = state_reg;
        tick_next        = tick_reg;
        src_next         = src_reg;
        issue_cnt_next   = issue_cnt_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        hit_next         = hit_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        peer_valid_next  = peer_valid_reg;
        host_node_next   = host_node_reg;
        host_misses_next = host_misses_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        send_to_next     = send_to_reg;
        send_kind_next   = send_kind_reg;
        full_next        = full_reg;
        wr_en            = 1'b0;
        wr_idx           = cmp_idx_reg;
        wr_data          = rd_data;
        rd_en            = 1'b0;
        rd_idx           = issue_cnt_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    src_next        = cmd.source_id;
                    tick_next       = (cmd.operation == kplt_pkg::OP_TICK);
                    issue_cnt_next  = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    case (cmd.operation)
                        kplt_pkg::OP_REQUEST:
                        begin
                            if (for_me)
                            begin
                                state_next = ST_SCAN;
                            end
                            else if (for_any)
                            begin
                                // answer only, no table lookup: treat as already known
                                hit_next   = 1'b1;
                                state_next = ST_FINISH;
                            end
                        end
                        kplt_pkg::OP_RESPONSE:
                        begin
                            if ((host_node_reg == kplt_pkg::ANY_ID) || for_me)
                            begin
                                host_node_next   = cmd.source_id;
                                host_misses_next = '0;
                            end
                        end
                        kplt_pkg::OP_TICK:
                        begin
                            host_misses_next = host_aged;
                            if (host_aged > max_attempts_reg)
                            begin
                                host_node_next = kplt_pkg::ANY_ID;
                            end
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issue_cnt_reg < CNT_W'(MAX_PEERS))
                begin
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    out_valid_next = 1'b1;
                    if (tick_reg)
                    begin
                        send_to_next   = host_node_reg;
                        send_kind_next = kplt_pkg::KIND_REQUEST;
                        full_next      = 1'b0;
                    end
                    else
                    begin
                        send_to_next   = src_reg;
                        send_kind_next = kplt_pkg::KIND_RESPONSE;
                        full_next      = !hit_reg && !free_found_reg;
                        // new peer goes to the first free slot seen in the walk
                        if (!hit_reg && free_found_reg)
                        begin
                            wr_en                         = 1'b1;
                            wr_idx                        = free_idx_reg;
                            wr_data.node                  = src_reg;
                            wr_data.misses                = '0;
                            peer_valid_next[free_idx_reg] = 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // compare stage: one entry a cycle, each entry touched once per walk
        if (cmp_valid_reg)
        begin
            if (tick_reg)
            begin
                if (entry_valid)
                begin
                    wr_en          = 1'b1;
                    wr_idx         = cmp_idx_reg;
                    wr_data.node   = rd_data.node;
                    wr_data.misses = aged_miss;
                    if (aged_miss > max_attempts_reg)
                    begin
                        peer_valid_next[cmp_idx_reg] = 1'b0;
                    end
                end
            end
            else
            begin
                if (entry_valid && (rd_data.node == src_reg) && !hit_reg)
                begin
                    wr_en          = 1'b1;
                    wr_idx         = cmp_idx_reg;
                    wr_data.node   = rd_data.node;
                    wr_data.misses = '0;
                    hit_next       = 1'b1;
                end
                if (!entry_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmp_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            peer_valid_reg  <= '0;
            host_node_reg   <= kplt_pkg::ANY_ID;
            host_misses_reg <= '0;
            issue_cnt_reg   <= '0;
            hit_reg         <= 1'b0;
            free_found_reg  <= 1'b0;
            tick_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cmp_valid_reg   <= cmp_valid_next;
            out_valid_reg   <= out_valid_next;
            peer_valid_reg  <= peer_valid_next;
            host_node_reg   <= host_node_next;
            host_misses_reg <= host_misses_next;
            issue_cnt_reg   <= issue_cnt_next;
            hit_reg         <= hit_next;
            free_found_reg  <= free_found_next;
            tick_reg        <= tick_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        cmp_idx_reg   <= cmp_idx_next;
        free_idx_reg  <= free_idx_next;
        send_to_reg   <= send_to_next;
        send_kind_reg <= send_kind_next;
        full_reg      <= full_next;
    end

endmodule

>>> src/kplt_checker.sv
// port-level checker for the keepalive liveness table, bound to the top level
// depends on kplt_pkg and keepalive_peer_liveness_table_assert.svh
`include "keepalive_peer_liveness_table_assert.svh"

module kplt_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cmd_valid,
    input logic                      cmd_ready,
    input logic [1:0]                cmd_operation,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [kplt_pkg::ID_W-1:0] rsp_send_to,
    input logic                      rsp_send_kind,
    input logic                      rsp_peer_table_full
);

    // a held result keeps its send_to and send_kind
    `KPLT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_send_to) && $stable(rsp_send_kind))

    // a keepalive request going out never flags a full table
    `KPLT_ASSERT_SAME(a_req_not_full, clk, rst_n, rsp_valid && (rsp_send_kind == kplt_pkg::KIND_REQUEST), !rsp_peer_table_full)

    // a tick walks the table, so the next item waits
    `KPLT_ASSERT_NEXT(a_tick_busy, clk, rst_n, cmd_valid && cmd_ready && (cmd_operation == kplt_pkg::OP_TICK), !cmd_ready)

    // a response only updates the host and is done at once
    `KPLT_ASSERT_NEXT(a_resp_quick, clk, rst_n, cmd_valid && cmd_ready && (cmd_operation == kplt_pkg::OP_RESPONSE), cmd_ready)

endmodule

bind keepalive_peer_liveness_table kplt_checker u_kplt_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (cmd.valid),
    .cmd_ready           (cmd.ready),
    .cmd_operation       (cmd.operation),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_send_to         (rsp.send_to),
    .rsp_send_kind       (rsp.send_kind),
    .rsp_peer_table_full (rsp.peer_table_full)
);

>>> sim/keepalive_peer_liveness_table_test.sv
`timescale 1ns / 1ps
// self-checking bench for the keepalive liveness table: drives the command channel and the
// config port, predicts every outgoing keepalive and checks the response channel against it
// depends on kplt_pkg, kplt_if and keepalive_peer_liveness_table
module keepalive_peer_liveness_table_test;

    localparam int PEER_SLOTS    = 16;
    // long enough for full peer walks to finish, plus output hold
    localparam int SETTLE_CYCLES = 48;
    // a few more ids than peer slots, so the table fills up and overflows
    localparam int ID_POOL_SIZE  = 24;
    // undefined operation code, must be ignored
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [kplt_pkg::ID_W-1:0] send_to;
        logic                      send_kind;
        logic                      peer_table_full;
    } keepalive_msg_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [kplt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [kplt_pkg::CFG_DATA_W-1:0] cfg_data;

    kplt_cmd_if cmd ();
    kplt_rsp_if rsp ();

    keepalive_peer_liveness_table #(
        .MAX_PEERS (PEER_SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the block's registers and liveness state
    logic [kplt_pkg::ID_W-1:0]   node_id;
    logic [kplt_pkg::MISS_W-1:0] miss_limit;
    logic [kplt_pkg::ID_W-1:0]   host_id;
    logic [kplt_pkg::MISS_W-1:0] host_missed;
    logic                        slot_used   [PEER_SLOTS];
    logic [kplt_pkg::ID_W-1:0]   slot_node   [PEER_SLOTS];
    logic [kplt_pkg::MISS_W-1:0] slot_missed [PEER_SLOTS];

    // keepalives the block still owes us, oldest first
    keepalive_msg_t              pending_keepalives [$];

    int unsigned                 errors;
    // items that changed state or gave an answer; ignored ones are not counted
    int unsigned                 acted_items;
    int                          src_idle_pct;
    int                          sink_stall_pct;
    int                          hold_request;
    int                          hold_left;
    logic [kplt_pkg::ID_W-1:0]   id_pool [ID_POOL_SIZE];

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // adds one keepalive at the tail of the owed list
    function automatic void owe_keepalive(input keepalive_msg_t msg);
        pending_keepalives.insert(pending_keepalives.size(), msg);
    endfunction

    // ---------------------------------------------------------------------------------------
    // predictor: applies one accepted item to the mirror state and queues its keepalive
    // ---------------------------------------------------------------------------------------
    function automatic void predict_keepalive(input logic [1:0]                op,
                                              input logic [kplt_pkg::ID_W-1:0] src,
                                              input logic [kplt_pkg::ID_W-1:0] dst);
        keepalive_msg_t msg;
        int             free_slot;
        logic           known;
        int             i;
        free_slot = -1;
        known     = 1'b0;
        case (op)
            kplt_pkg::OP_REQUEST:
            begin
                // only answered when addressed to us or to anyone
                if (dst == kplt_pkg::ANY_ID || dst == node_id)
                begin
                    msg.send_to         = src;
                    msg.send_kind       = kplt_pkg::KIND_RESPONSE;
                    msg.peer_table_full = 1'b0;
                    // addressed to us: refresh or add the sender as a peer
                    // (with node_id of zero a request to anyone lands here too)
                    if (dst == node_id)
                    begin
                        for (i = 0; i < PEER_SLOTS; i++)
                        begin
                            if (slot_used[i] && slot_node[i] == src)
                            begin
                                slot_missed[i] = '0;
                                known          = 1'b1;
                                break;
                            end
                            if (!slot_used[i] && free_slot < 0)
                                free_slot = i;
                        end
                        if (!known)
                        begin
                            if (free_slot < 0)
                                msg.peer_table_full = 1'b1;
                            else
                            begin
                                slot_used[free_slot]   = 1'b1;
                                slot_node[free_slot]   = src;
                                slot_missed[free_slot] = '0;
                            end
                        end
                    end
                    owe_keepalive(msg);
                    acted_items++;
                end
            end
            kplt_pkg::OP_RESPONSE:
            begin
                // adopt the sender as host when none is known or when it answers us;
                // a sender of id zero leaves the host unknown
                if (host_id == kplt_pkg::ANY_ID || dst == node_id)
                begin
                    host_id     = src;
                    host_missed = '0;
                    acted_items++;
                end
            end
            kplt_pkg::OP_TICK:
            begin
                // host ages even once lost; counts stick at the top
                if (host_missed != kplt_pkg::MISS_SAT)
                    host_missed = host_missed + 1'b1;
                if (host_missed > miss_limit)
                    host_id = kplt_pkg::ANY_ID;
                for (i = 0; i < PEER_SLOTS; i++)
                begin
                    if (slot_used[i])
                    begin
                        if (slot_missed[i] != kplt_pkg::MISS_SAT)
                            slot_missed[i] = slot_missed[i] + 1'b1;
                        if (slot_missed[i] > miss_limit)
                            slot_used[i] = 1'b0;
                    end
                end
                msg.send_to         = host_id;
                msg.send_kind       = kplt_pkg::KIND_REQUEST;
                msg.peer_table_full = 1'b0;
                owe_keepalive(msg);
                acted_items++;
            end
            default:
            begin
                // unknown operation: nothing happens
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------------------------
    // mismatch reporting and result checking
    // ---------------------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [kplt_pkg::ID_W-1:0] got,
                                   input logic [kplt_pkg::ID_W-1:0] want);
        $display("mismatch at %0t ns: %s, got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    // every accepted keepalive is held against the oldest one still owed
    always @(posedge clk)
    begin
        keepalive_msg_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_keepalives.size() == 0)
                report_mismatch("keepalive with none expected, send_to", rsp.send_to, '0);
            else
            begin
                want = pending_keepalives.pop_front();
                if (rsp.send_to !== want.send_to)
                    report_mismatch("send_to", rsp.send_to, want.send_to);
                if (rsp.send_kind !== want.send_kind)
                    report_mismatch("send_kind", kplt_pkg::ID_W'(rsp.send_kind),
                                    kplt_pkg::ID_W'(want.send_kind));
                if (rsp.peer_table_full !== want.peer_table_full)
                    report_mismatch("peer_table_full", kplt_pkg::ID_W'(rsp.peer_table_full),
                                    kplt_pkg::ID_W'(want.peer_table_full));
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is asked for
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ---------------------------------------------------------------------------------------
    // shared drivers
    // ---------------------------------------------------------------------------------------

    // offers one item, possibly after an idle gap, and returns once it is taken
    task automatic send_item(input logic [1:0] op, input logic [kplt_pkg::ID_W-1:0] src,
                             input logic [kplt_pkg::ID_W-1:0] dst);
        int gap;
        gap = 0;
        if (src_idle_pct > 0)
        begin
            while ($urandom_range(99) < src_idle_pct)
                gap++;
            // now and then a longer pause, so gaps land on every step of a peer walk
            if ($urandom_range(19) == 0)
                gap += $urandom_range(1, 24);
        end
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid          <= 1'b1;
        cmd.operation      <= op;
        cmd.source_id      <= src;
        cmd.destination_id <= dst;
        do
        begin
            @(posedge clk);
        end
        while (!cmd.ready);
        predict_keepalive(op, src, dst);
    endtask

    // stop offering, let every owed keepalive arrive, then let the block go quiet
    task automatic settle();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending_keepalives.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes both registers back to back; only called while the block is quiet
    task automatic write_config(input logic [kplt_pkg::ID_W-1:0]   id,
                                input logic [kplt_pkg::MISS_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= kplt_pkg::REG_MY_ID;
        cfg_data  <= id;
        @(posedge clk);
        cfg_index <= kplt_pkg::REG_MAX_ATTEMPTS;
        cfg_data  <= {{(kplt_pkg::CFG_DATA_W - kplt_pkg::MISS_W){1'b0}}, limit};
        @(posedge clk);
        cfg_we     <= 1'b0;
        node_id    = id;
        miss_limit = limit;
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // mostly plausible traffic around a small set of nodes, with some noise mixed in
    task automatic send_random_item();
        int unsigned               pick;
        int unsigned               route;
        logic [1:0]                op;
        logic [kplt_pkg::ID_W-1:0] src;
        logic [kplt_pkg::ID_W-1:0] dst;
        pick  = $urandom_range(99);
        route = $urandom_range(99);
        if ($urandom_range(99) < 85)
            src = id_pool[$urandom_range(ID_POOL_SIZE - 1)];
        else
            src = kplt_pkg::ID_W'($urandom);
        if (route < 50)
            dst = node_id;
        else if (route < 70)
            dst = kplt_pkg::ANY_ID;
        else if (route < 90)
            dst = kplt_pkg::ID_W'($urandom);
        else
            dst = id_pool[$urandom_range(ID_POOL_SIZE - 1)];
        if (pick < 42)
            op = kplt_pkg::OP_REQUEST;
        else if (pick < 62)
            op = kplt_pkg::OP_RESPONSE;
        else if (pick < 90)
        begin
            // ids ride along on a tick but are ignored; keep them busy anyway
            op  = kplt_pkg::OP_TICK;
            src = kplt_pkg::ID_W'($urandom);
            dst = kplt_pkg::ID_W'($urandom);
        end
        else
            op = OP_UNUSED;
        send_item(op, src, dst);
    endtask

    // one random phase under one setting of the registers and of idling
    task automatic run_random_phase(input logic [kplt_pkg::ID_W-1:0]   id,
                                    input logic [kplt_pkg::MISS_W-1:0] limit,
                                    input int src_pct, input int sink_pct,
                                    input int unsigned count);
        int unsigned start;
        int          i;
        settle();
        write_config(id, limit);
        // the pool always holds the wildcard, the top id and our own id
        id_pool[0] = kplt_pkg::ANY_ID;
        id_pool[1] = '1;
        id_pool[2] = id;
        for (i = 3; i < ID_POOL_SIZE; i++)
            id_pool[i] = kplt_pkg::ID_W'($urandom_range(1, 65535));
        set_idling(src_pct, sink_pct);
        start = acted_items;
        while (acted_items - start < count)
            send_random_item();
    endtask

    // ---------------------------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------------------------

    // request routing, peer add and refresh, host adoption, all under the reset settings
    task automatic test_requests_and_responses();
        set_idling(0, 0);
        // for another node: ignored
        send_item(kplt_pkg::OP_REQUEST, 16'h1234, 16'h0002);
        // to anyone: answered, not added
        send_item(kplt_pkg::OP_REQUEST, 16'hFFFF, kplt_pkg::ANY_ID);
        // to us from id zero: added
        send_item(kplt_pkg::OP_REQUEST, 16'h0000, kplt_pkg::MY_ID_RESET);
        // new peer
        send_item(kplt_pkg::OP_REQUEST, 16'hFFFF, kplt_pkg::MY_ID_RESET);
        // known peer, count cleared
        send_item(kplt_pkg::OP_REQUEST, 16'hFFFF, kplt_pkg::MY_ID_RESET);
        // no host yet: adopted
        send_item(kplt_pkg::OP_RESPONSE, 16'hABCD, 16'h7777);
        // host known, not for us: ignored
        send_item(kplt_pkg::OP_RESPONSE, 16'h5555, 16'h7777);
        // for us: takes over
        send_item(kplt_pkg::OP_RESPONSE, 16'h5555, kplt_pkg::MY_ID_RESET);
        send_item(kplt_pkg::OP_TICK, 16'h0000, 16'h0000);
        // id zero as host: still none
        send_item(kplt_pkg::OP_RESPONSE, 16'h0000, kplt_pkg::MY_ID_RESET);
        // so the next sender is adopted
        send_item(kplt_pkg::OP_RESPONSE, 16'h2222, 16'h3333);
        // undefined operation: ignored
        send_item(OP_UNUSED, 16'hFFFF, kplt_pkg::MY_ID_RESET);
        send_item(kplt_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
        settle();
    endtask

    // loss of host and peers at the smallest limit, then our id set to the wildcard
    task automatic test_ageing_and_loss();
        write_config(16'hFFFF, 4'd0);
        send_item(kplt_pkg::OP_REQUEST, 16'h0101, 16'hFFFF);
        // peer and host both lost
        send_item(kplt_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_item(kplt_pkg::OP_RESPONSE, 16'h0202, 16'hFFFF);
        send_item(kplt_pkg::OP_TICK, 16'h0000, 16'h0000);
        settle();
        // with our id of zero a request to anyone is also a request to us
        write_config(kplt_pkg::ANY_ID, 4'd14);
        send_item(kplt_pkg::OP_REQUEST, 16'h0303, kplt_pkg::ANY_ID);
        send_item(kplt_pkg::OP_RESPONSE, 16'h0404, kplt_pkg::ANY_ID);
        send_item(kplt_pkg::OP_TICK, 16'h0000, 16'h0000);
        settle();
    endtask

    // fill every peer slot, then one more new sender must be flagged and left out
    task automatic test_table_full();
        int i;
        write_config(16'h0042, 4'd14);
        for (i = 0; i < PEER_SLOTS; i++)
            send_item(kplt_pkg::OP_REQUEST, kplt_pkg::ID_W'(16'h1000 + i * 16'h0111),
                      16'h0042);
        // overflow: flagged
        send_item(kplt_pkg::OP_REQUEST, 16'h8888, 16'h0042);
        // known peer: fine
        send_item(kplt_pkg::OP_REQUEST, 16'h1000, 16'h0042);
        // to anyone: table untouched
        send_item(kplt_pkg::OP_REQUEST, 16'h9999, kplt_pkg::ANY_ID);
        send_item(kplt_pkg::OP_TICK, 16'h0000, 16'h0000);
        settle();
    endtask

    // long random runs across register settings and idling patterns
    task automatic test_random_traffic();
        run_random_phase(kplt_pkg::ID_W'($urandom_range(1, 65535)),
                         kplt_pkg::MAX_ATTEMPTS_RST, 0, 0, 170);
        run_random_phase(16'hFFFF, 4'd14, 47, 0, 170);
        run_random_phase(kplt_pkg::ANY_ID, 4'd0, 0, 47, 160);
        run_random_phase(kplt_pkg::ID_W'($urandom_range(1, 65535)), kplt_pkg::MISS_SAT,
                         31, 31, 170);
        run_random_phase(kplt_pkg::MY_ID_RESET, 4'd1, 0, 0, 160);
        run_random_phase(kplt_pkg::ID_W'($urandom_range(1, 65535)),
                         kplt_pkg::MISS_W'($urandom_range(2, 13)), 31, 31, 170);
        settle();
    endtask

    // receiver holds off long enough for the block to back up and stall its input;
    // then the sender waits for every keepalive before carrying on
    task automatic test_back_pressure();
        int i;
        write_config(16'h00A5, 4'd14);
        set_idling(0, 0);
        hold_request = 300;
        for (i = 0; i < 30; i++)
        begin
            if (i % 3 == 0)
                send_item(kplt_pkg::OP_TICK, kplt_pkg::ID_W'($urandom),
                          kplt_pkg::ID_W'($urandom));
            else
                send_item(kplt_pkg::OP_REQUEST, kplt_pkg::ID_W'($urandom_range(0, 20)),
                          16'h00A5);
        end
        // sender pause until the queue is empty
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending_keepalives.size() != 0)
            @(posedge clk);
        set_idling(0, 47);
        for (i = 0; i < 20; i++)
        begin
            if (i % 4 == 0)
                send_item(kplt_pkg::OP_TICK, kplt_pkg::ID_W'($urandom),
                          kplt_pkg::ID_W'($urandom));
            else
                send_item(kplt_pkg::OP_REQUEST, kplt_pkg::ID_W'($urandom_range(0, 20)),
                          kplt_pkg::ANY_ID);
        end
        settle();
    endtask

    // ---------------------------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------------------------
    initial
    begin
        int i;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = kplt_pkg::REG_MY_ID;
        cfg_data           = '0;
        cmd.valid          = 1'b0;
        cmd.operation      = kplt_pkg::OP_REQUEST;
        cmd.source_id      = '0;
        cmd.destination_id = '0;
        rsp.ready          = 1'b0;
        errors             = 0;
        acted_items        = 0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        hold_request       = 0;
        hold_left          = 0;
        // mirror starts from the reset state
        node_id     = kplt_pkg::MY_ID_RESET;
        miss_limit  = kplt_pkg::MAX_ATTEMPTS_RST;
        host_id     = kplt_pkg::ANY_ID;
        host_missed = '0;
        for (i = 0; i < PEER_SLOTS; i++)
        begin
            slot_used[i]   = 1'b0;
            slot_node[i]   = '0;
            slot_missed[i] = '0;
        end
        for (i = 0; i < ID_POOL_SIZE; i++)
            id_pool[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_requests_and_responses();
        test_ageing_and_loss();
        test_table_full();
        test_random_traffic();
        test_back_pressure();
        settle();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #9_600_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/kplt_pkg.sv
src/kplt_if.sv
src/kplt_peer_ram.sv
src/keepalive_peer_liveness_table.sv
src/kplt_checker.sv
sim/keepalive_peer_liveness_table_test.sv
